@@ rtl/core/bsc_pkg.sv @@
// package for the barometric compensation core: types, constants and helpers
package bsc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  // payload width carried alongside each divider request
  localparam int unsigned DivSideW = 53;

  typedef enum logic [CfgIdxW-1:0] {
    REG_AC1_AC2 = 3'd0,
    REG_AC3_AC4 = 3'd1,
    REG_AC5_AC6 = 3'd2,
    REG_B1_B2 = 3'd3,
    REG_MC_MD = 3'd4,
    REG_OSS = 3'd5
  } reg_idx_t;

  localparam logic signed [31:0] B6Offset = 32'sd4000;
  localparam logic [31:0] PressBase = 32'd50000;
  localparam logic signed [31:0] PCoefA = 32'sd3038;
  localparam logic signed [31:0] PCoefB = -32'sd7357;
  localparam logic signed [31:0] PCoefC = 32'sd3791;
  localparam logic signed [31:0] B4Bias = 32'sd32768;
  localparam logic signed [12:0] TempMax = 13'sd4095;
  localparam logic signed [12:0] TempMin = -13'sd4096;
  localparam logic [17:0] PressMax = 18'h3FFFF;

  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
    logic [1:0] oss;
  } cal_t;

  // signed 32-bit multiply, wrapped
  function automatic logic signed [31:0] wmul(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] prod;
    prod = a * b;
    return prod[31:0];
  endfunction

endpackage

@@ rtl/core/baro_sensor_compensation_core.sv @@
// top level of the barometric compensation core
//   channel | dir | contents
//   s_axis  | in  | tdata: raw_temperature[15:0], raw_pressure[34:16]
//   m_axis  | out | tdata: temperature_tenths[12:0], pressure_pa[30:13]; tuser: fault
//   cfg     | in  | cfg_we, cfg_addr (register index), cfg_wdata
// one sample pair per cycle while the output is not held; latency is set mostly by two 32-stage dividers
// the whole pipeline advances together and holds when the output register is full
// and not taken; reset clears all valid bits and the calibration registers
module baro_sensor_compensation_core import bsc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [39:0]         s_axis_tdata,  // raw_temperature, raw_pressure
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,  // temperature_tenths, pressure_pa
  output logic                m_axis_tuser,  // fault
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata
);
  cal_t cal;
  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  bsc_cfg u_cfg (.clk, .rst, .cfg_we, .cfg_addr, .cfg_wdata, .cal);

  logic               t_v, t_f;
  logic signed [12:0] t_t;
  logic signed [31:0] t_b6, t_sq;
  logic [18:0]        t_up;
  bsc_temp u_temp (
    .clk, .rst, .en, .cal,
    .in_valid(s_axis_tvalid && s_axis_tready),
    .ut(s_axis_tdata[15:0]),
    .up_in(s_axis_tdata[34:16]),
    .out_valid(t_v), .out_fault(t_f), .out_temp(t_t),
    .out_b6(t_b6), .out_sq(t_sq), .out_up(t_up)
  );

  logic               o_f;
  logic signed [12:0] o_t;
  logic [17:0]        o_p;
  bsc_press u_press (
    .clk, .rst, .en, .cal,
    .in_valid(t_v), .in_fault(t_f), .in_temp(t_t),
    .in_b6(t_b6), .in_sq(t_sq), .in_up(t_up),
    .out_valid(m_axis_tvalid), .out_fault(o_f), .out_temp(o_t), .out_press(o_p)
  );

  assign m_axis_tdata = {1'b0, o_p, o_t};
  assign m_axis_tuser = o_f;
endmodule

@@ rtl/core/bsc_div.sv @@
// pipelined restoring divider, one quotient bit per stage, with a side payload
module bsc_div import bsc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [31:0]         num,
  input  logic [31:0]         den,
  input  logic [DivSideW-1:0] side_in,
  output logic                out_valid,
  output logic [31:0]         quo,
  output logic [DivSideW-1:0] side_out
);
  localparam int unsigned N = 32;

  logic                vld  [N+1];
  logic [31:0]         q    [N+1];
  logic [32:0]         r    [N+1];
  logic [31:0]         d    [N+1];
  logic [DivSideW-1:0] sd   [N+1];

  assign vld[0] = in_valid;
  assign q[0] = num;
  assign r[0] = '0;
  assign d[0] = den;
  assign sd[0] = side_in;

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [32:0] sh;
    logic [32:0] diff;
    assign sh = {r[s][31:0], q[s][31]};
    assign diff = sh - {1'b0, d[s]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d[s+1] <= d[s];
        sd[s+1] <= sd[s];
        if (!diff[32]) begin
          r[s+1] <= diff;
          q[s+1] <= {q[s][30:0], 1'b1};
        end else begin
          r[s+1] <= sh;
          q[s+1] <= {q[s][30:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[N];
  assign quo = q[N];
  assign side_out = sd[N];
endmodule

@@ rtl/core/bsc_cfg.sv @@
// calibration register file
module bsc_cfg import bsc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output cal_t                cal
);
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_AC1_AC2: begin
          cal.ac1 <= cfg_wdata[31:16];
          cal.ac2 <= cfg_wdata[15:0];
        end
        REG_AC3_AC4: begin
          cal.ac3 <= cfg_wdata[31:16];
          cal.ac4 <= cfg_wdata[15:0];
        end
        REG_AC5_AC6: begin
          cal.ac5 <= cfg_wdata[31:16];
          cal.ac6 <= cfg_wdata[15:0];
        end
        REG_B1_B2: begin
          cal.b1 <= cfg_wdata[31:16];
          cal.b2 <= cfg_wdata[15:0];
        end
        REG_MC_MD: begin
          cal.mc <= cfg_wdata[31:16];
          cal.md <= cfg_wdata[15:0];
        end
        REG_OSS: cal.oss <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end
endmodule

@@ rtl/core/bsc_temp.sv @@
// temperature half: x1 product, b5 divide, then b6 and its square
module bsc_temp import bsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  cal_t               cal,
  input  logic               in_valid,
  input  logic [15:0]        ut,
  input  logic [18:0]        up_in,
  output logic               out_valid,
  output logic               out_fault,
  output logic signed [12:0] out_temp,
  output logic signed [31:0] out_b6,
  output logic signed [31:0] out_sq,
  output logic [18:0]        out_up
);
  // stage 1: x1 product
  logic               s1_v;
  logic signed [31:0] s1_prod;
  logic [18:0]        s1_up;
  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod <= wmul($signed({16'd0, ut}) - $signed({16'd0, cal.ac6}),
                      $signed({16'd0, cal.ac5}));
      s1_up <= up_in;
    end
  end

  // stage 2: divisor and dividend magnitudes
  logic signed [31:0] x1_c, den_c, numv_c;
  assign x1_c = s1_prod >>> 15;
  assign den_c = x1_c + 32'(cal.md);
  assign numv_c = 32'(cal.mc) <<< 11;

  logic               s2_v, s2_zero;
  logic [31:0]        s2_num, s2_den;
  logic               s2_neg;
  logic signed [31:0] s2_x1;
  logic [18:0]        s2_up;
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (en) s2_v <= s1_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_zero <= den_c == 32'sd0;
      s2_num <= numv_c[31] ? 32'(-numv_c) : numv_c;
      s2_den <= den_c[31] ? 32'(-den_c) : den_c;
      s2_neg <= numv_c[31] ^ den_c[31];
      s2_x1 <= x1_c;
      s2_up <= s1_up;
    end
  end

  logic                dv;
  logic [31:0]         dq;
  logic [DivSideW-1:0] dside;
  bsc_div u_div (
    .clk, .rst, .en,
    .in_valid(s2_v),
    .num(s2_num),
    .den(s2_zero ? 32'd1 : s2_den),
    .side_in({s2_zero, s2_neg, s2_x1, s2_up}),
    .out_valid(dv),
    .quo(dq),
    .side_out(dside)
  );

  logic               d_zero, d_neg;
  logic signed [31:0] d_x1;
  logic [18:0]        d_up;
  assign {d_zero, d_neg, d_x1, d_up} = dside;

  // stage after divide: b5, t, b6
  logic signed [31:0] b5_c, t_c, b6_c;
  assign b5_c = d_x1 + (d_neg ? -$signed(dq) : $signed(dq));
  assign t_c = (b5_c + 32'sd8) >>> 4;
  assign b6_c = b5_c - B6Offset;

  logic               s3_v, s3_f;
  logic signed [12:0] s3_t;
  logic signed [31:0] s3_b6;
  logic [18:0]        s3_up;
  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (en) s3_v <= dv;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_f <= d_zero;
      if (t_c > 32'(TempMax)) s3_t <= TempMax;
      else if (t_c < 32'(TempMin)) s3_t <= TempMin;
      else s3_t <= t_c[12:0];
      s3_b6 <= b6_c;
      s3_up <= d_up;
    end
  end

  // stage: square of b6
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= s3_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_fault <= s3_f;
      out_temp <= s3_t;
      out_b6 <= s3_b6;
      out_sq <= wmul(s3_b6, s3_b6) >>> 12;
      out_up <= s3_up;
    end
  end
endmodule

@@ rtl/core/bsc_press.sv @@
// pressure half: b3, b4, b7, divide by b4 and final correction
module bsc_press import bsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  cal_t               cal,
  input  logic               in_valid,
  input  logic               in_fault,
  input  logic signed [12:0] in_temp,
  input  logic signed [31:0] in_b6,
  input  logic signed [31:0] in_sq,
  input  logic [18:0]        in_up,
  output logic               out_valid,
  output logic               out_fault,
  output logic signed [12:0] out_temp,
  output logic [17:0]        out_press
);
  // p1: four products
  logic               p1_v, p1_f;
  logic signed [12:0] p1_t;
  logic [18:0]        p1_up;
  logic signed [31:0] p1_m1, p1_m2, p1_m3, p1_m4;
  always_ff @(posedge clk) begin
    if (rst) p1_v <= 1'b0;
    else if (en) p1_v <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p1_f <= in_fault;
      p1_t <= in_temp;
      p1_up <= in_up;
      p1_m1 <= wmul(32'(cal.b2), in_sq) >>> 11;
      p1_m2 <= wmul(32'(cal.ac2), in_b6) >>> 11;
      p1_m3 <= wmul(32'(cal.ac3), in_b6) >>> 13;
      p1_m4 <= wmul(32'(cal.b1), in_sq) >>> 16;
    end
  end

  // p2: b3 and the b4 factor
  logic signed [31:0] b3a_c, b3s_c, b3_c, x3_c;
  assign b3a_c = (32'(cal.ac1) <<< 2) + p1_m1 + p1_m2;
  assign b3s_c = b3a_c <<< cal.oss;
  assign b3_c = (b3s_c + 32'sd2) / 32'sd4;
  assign x3_c = (p1_m3 + p1_m4 + 32'sd2) >>> 2;

  logic               p2_v, p2_f;
  logic signed [12:0] p2_t;
  logic [18:0]        p2_up;
  logic signed [31:0] p2_b3;
  logic [31:0]        p2_b4p;
  always_ff @(posedge clk) begin
    if (rst) p2_v <= 1'b0;
    else if (en) p2_v <= p1_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p2_f <= p1_f;
      p2_t <= p1_t;
      p2_up <= p1_up;
      p2_b3 <= b3_c;
      p2_b4p <= x3_c + B4Bias;
    end
  end

  // p3: b4 and b7 products
  logic [63:0] b4m_c, b7m_c;
  assign b4m_c = {48'd0, cal.ac4} * {32'd0, p2_b4p};
  assign b7m_c = {32'd0, 32'({13'd0, p2_up} - p2_b3)} * {32'd0, PressBase >> cal.oss};

  logic               p3_v, p3_f;
  logic signed [12:0] p3_t;
  logic [31:0]        p3_b4, p3_b7;
  always_ff @(posedge clk) begin
    if (rst) p3_v <= 1'b0;
    else if (en) p3_v <= p2_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p3_f <= p2_f;
      p3_t <= p2_t;
      p3_b4 <= {15'd0, b4m_c[31:15]};
      p3_b7 <= b7m_c[31:0];
    end
  end

  logic p3_zero, p3_big;
  assign p3_zero = p3_b4 == 32'd0;
  assign p3_big = p3_b7[31];

  logic                dv;
  logic [31:0]         dq;
  logic [DivSideW-1:0] dside;
  bsc_div u_div (
    .clk, .rst, .en,
    .in_valid(p3_v),
    .num(p3_big ? p3_b7 : {p3_b7[30:0], 1'b0}),
    .den(p3_zero ? 32'd1 : p3_b4),
    .side_in({38'd0, p3_f | p3_zero, p3_big, p3_t}),
    .out_valid(dv),
    .quo(dq),
    .side_out(dside)
  );

  logic               d_f, d_big;
  logic signed [12:0] d_t;
  assign {d_f, d_big, d_t} = dside[14:0];

  // p4: p and its square
  logic signed [31:0] p_c, ps_c;
  assign p_c = d_big ? {dq[30:0], 1'b0} : dq;
  assign ps_c = p_c >>> 8;

  logic               p4_v, p4_f;
  logic signed [12:0] p4_t;
  logic signed [31:0] p4_p, p4_sq, p4_x2;
  always_ff @(posedge clk) begin
    if (rst) p4_v <= 1'b0;
    else if (en) p4_v <= dv;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p4_f <= d_f;
      p4_t <= d_t;
      p4_p <= p_c;
      p4_sq <= wmul(ps_c, ps_c);
      p4_x2 <= wmul(PCoefB, p_c) >>> 16;
    end
  end

  // p5: scaled square
  logic               p5_v, p5_f;
  logic signed [12:0] p5_t;
  logic signed [31:0] p5_p, p5_x1, p5_x2;
  always_ff @(posedge clk) begin
    if (rst) p5_v <= 1'b0;
    else if (en) p5_v <= p4_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p5_f <= p4_f;
      p5_t <= p4_t;
      p5_p <= p4_p;
      p5_x1 <= wmul(p4_sq, PCoefA) >>> 16;
      p5_x2 <= p4_x2;
    end
  end

  // p6: final sum and saturation
  logic signed [31:0] pf_c;
  assign pf_c = p5_p + ((p5_x1 + p5_x2 + PCoefC) >>> 4);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= p5_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_fault <= p5_f;
      if (p5_f) begin
        out_temp <= '0;
        out_press <= '0;
      end else begin
        out_temp <= p5_t;
        if (pf_c[31]) out_press <= '0;
        else if (pf_c > $signed({14'd0, PressMax})) out_press <= PressMax;
        else out_press <= pf_c[17:0];
      end
    end
  end
endmodule

@@ rtl/core/bsc_checker.sv @@
// port-level checks for the compensation core
module bsc_checker import bsc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  // a fault result carries zero values
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[30:0] == 31'd0)
    else $error("fault result not zeroed");

  // input side stalls exactly when a result is held back
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready mismatch");

  // a held result does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result out of reset");
endmodule

bind baro_sensor_compensation_core bsc_checker u_bsc_checker (
  .clk, .rst, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tuser
);
